// File: rtl/dvru_pkg.sv
`default_nettype none
package dvru_pkg;

  localparam int ROUTE_ENTRIES = 64;
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

  localparam logic       REQ_UPDATE = 1'b0;
  localparam logic       REQ_READ   = 1'b1;
  localparam logic [15:0] COST_MAX  = 16'hFFFF;

  typedef struct packed {
    logic        req_type;
    logic [31:0] neighbor_addr;
    logic [15:0] link_metric;
    logic [31:0] dest_addr;
    logic [15:0] advertised_distance;
    logic [5:0]  read_index;
    logic        last_of_pass;
  } in_t;

  typedef struct packed {
    logic        changed;
    logic        pass_changed;
    logic        table_full_drop;
    logic        entry_valid;
    logic [31:0] entry_dest;
    logic [31:0] entry_next_hop;
    logic [15:0] entry_cost;
    logic [6:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] next_hop;
    logic [15:0] cost;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

endpackage
`default_nettype wire

// File: rtl/dvru_ram.sv
`default_nettype none
module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/distance_vector_route_update.sv
`default_nettype none
// distance-vector route table engine
// input: an item is taken at a rising edge with start high and busy low.
//   req_type 0 is an advertised entry update, 1 reads the table slot at
//   read_index. busy stays high while an item is being worked on.
// output: one result per item, shown for exactly one cycle with out_valid
//   high; the receiver cannot stall, so it must take every result.
// scan: an update scans the table one slot per cycle through a single
//   ram read port and one dest compare; it stops at the first slot whose
//   dest matches, else after the last counted slot it inserts or drops
//   (straight away when the table is empty). a read in range goes through
//   ST_READ, an out-of-range read is answered straight from idle.
//   busy falls in the cycle the result is shown, so the next item can be
//   taken then.
// reset: route count and pass change flag clear; table contents are not
//   cleared, slots at or beyond the count are never looked at.
module distance_vector_route_update (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire dvru_pkg::in_t  in_item,
  output logic                out_valid,
  output dvru_pkg::out_t      out_res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  dvru_pkg::in_t                req_r, req_nxt;
  logic [15:0]                  cost_r, cost_nxt;
  logic [dvru_pkg::IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [dvru_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                         accum_r, accum_nxt;
  logic                         out_valid_r, out_valid_nxt;
  dvru_pkg::out_t               out_r, out_nxt;

  logic                         wr_en;
  logic [dvru_pkg::IDX_W-1:0]   wr_addr;
  dvru_pkg::route_t             wr_route;
  logic [dvru_pkg::IDX_W-1:0]   rd_addr;
  dvru_pkg::route_t             rd_route;

  logic [16:0]                  cost_sum;
  logic [15:0]                  cost_sat;
  logic                         scan_last;
  logic                         table_full;
  logic                         read_ok;

  dvru_ram #(
    .WIDTH (dvru_pkg::ROUTE_W),
    .DEPTH (dvru_pkg::ROUTE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_route),
    .rd_addr (rd_addr),
    .rd_data (rd_route)
  );

  assign cost_sum   = {1'b0, in_item.link_metric} + {1'b0, in_item.advertised_distance};
  assign cost_sat   = cost_sum[16] ? dvru_pkg::COST_MAX : cost_sum[15:0];
  assign scan_last  = (dvru_pkg::CNT_W'(scan_idx_r) + dvru_pkg::CNT_W'(1)) == count_r;
  assign table_full = count_r == dvru_pkg::CNT_W'(dvru_pkg::ROUTE_ENTRIES);
  assign read_ok    = 32'(in_item.read_index) < 32'(count_r);

  always_comb begin
    logic fin;
    logic fin_chg;
    logic fin_drop;
    logic acc_all;

    state_nxt     = state_r;
    req_nxt       = req_r;
    cost_nxt      = cost_r;
    scan_idx_nxt  = scan_idx_r;
    count_nxt     = count_r;
    accum_nxt     = accum_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = scan_idx_r;
    wr_route      = '{dest: req_r.dest_addr, next_hop: req_r.neighbor_addr, cost: cost_r};
    rd_addr       = scan_idx_r + dvru_pkg::IDX_W'(1);
    fin           = 1'b0;
    fin_chg       = 1'b0;
    fin_drop      = 1'b0;
    acc_all       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt  = in_item;
          cost_nxt = cost_sat;
          if (in_item.req_type == dvru_pkg::REQ_READ) begin
            if (read_ok) begin
              rd_addr   = dvru_pkg::IDX_W'(in_item.read_index);
              state_nxt = ST_READ;
            end else begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
              out_nxt.entry_count = 7'(count_r);
            end
          end else begin
            scan_idx_nxt = '0;
            rd_addr      = '0;
            state_nxt    = (count_r == '0) ? ST_MISS : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_route.dest == req_r.dest_addr) begin
          if (cost_r < rd_route.cost) begin
            wr_en   = 1'b1;
            wr_addr = scan_idx_r;
            fin_chg = 1'b1;
          end
          fin = 1'b1;
        end else if (scan_last) begin
          state_nxt = ST_MISS;
        end else begin
          scan_idx_nxt = scan_idx_r + dvru_pkg::IDX_W'(1);
        end
      end
      ST_MISS: begin
        fin = 1'b1;
        if (!table_full) begin
          wr_en     = 1'b1;
          wr_addr   = dvru_pkg::IDX_W'(count_r);
          count_nxt = count_r + dvru_pkg::CNT_W'(1);
          fin_chg   = 1'b1;
        end else begin
          fin_drop = 1'b1;
        end
      end
      ST_READ: begin
        state_nxt              = ST_IDLE;
        out_valid_nxt          = 1'b1;
        out_nxt                = '0;
        out_nxt.entry_valid    = 1'b1;
        out_nxt.entry_dest     = rd_route.dest;
        out_nxt.entry_next_hop = rd_route.next_hop;
        out_nxt.entry_cost     = rd_route.cost;
        out_nxt.entry_count    = 7'(count_r);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      acc_all                 = accum_r | fin_chg;
      state_nxt               = ST_IDLE;
      out_valid_nxt           = 1'b1;
      out_nxt                 = '0;
      out_nxt.changed         = fin_chg;
      out_nxt.table_full_drop = fin_drop;
      out_nxt.pass_changed    = req_r.last_of_pass & acc_all;
      out_nxt.entry_count     = 7'(count_nxt);
      accum_nxt               = req_r.last_of_pass ? 1'b0 : acc_all;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      accum_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      accum_r     <= accum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cost_r     <= cost_nxt;
    scan_idx_r <= scan_idx_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire

// File: rtl/dvru_checker.sv
`default_nettype none
module dvru_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire dvru_pkg::in_t  in_item,
  input wire logic           out_valid,
  input wire dvru_pkg::out_t out_res
);

  // result shows up only once the engine is free again
  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // every update occupies the engine
  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.req_type == dvru_pkg::REQ_UPDATE) |=> busy)
    else $error("update accepted without going busy");

  // engine frees itself only by delivering a result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped with no result");

  // read results carry no update flags
  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.entry_valid) |->
      (!out_res.changed && !out_res.pass_changed && !out_res.table_full_drop))
    else $error("read result with update flags");

  // a drop never counts as a change
  a_drop_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.table_full_drop) |-> !out_res.changed)
    else $error("drop flagged together with change");

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_res   (out_res)
);
`default_nettype wire

// File: sim/distance_vector_route_update_tb.sv
`timescale 1ns / 100ps

module distance_vector_route_update_tb;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  dvru_pkg::in_t in_item = '0;
  logic out_valid;
  dvru_pkg::out_t out_res;

  distance_vector_route_update u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // route table as the engine should hold it
  logic [31:0] rt_dest [dvru_pkg::ROUTE_ENTRIES];
  logic [31:0] rt_hop [dvru_pkg::ROUTE_ENTRIES];
  logic [15:0] rt_cost [dvru_pkg::ROUTE_ENTRIES];
  int rt_count = 0;
  logic pass_acc = 1'b0;

  dvru_pkg::in_t adverts[$];
  dvru_pkg::out_t route_replies[$];
  logic [31:0] dest_pool[$];
  int fault_count = 0;
  int gap_left = 0;
  int calm_left = 0;
  logic item_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic dvru_pkg::out_t relax_route(dvru_pkg::in_t it);
    dvru_pkg::out_t r;
    logic [16:0] sum;
    logic [15:0] cost;
    int hit;
    r = '0;
    if (it.req_type == dvru_pkg::REQ_READ) begin
      if (int'(it.read_index) < rt_count) begin
        r.entry_valid = 1'b1;
        r.entry_dest = rt_dest[it.read_index];
        r.entry_next_hop = rt_hop[it.read_index];
        r.entry_cost = rt_cost[it.read_index];
      end
    end else begin
      sum = {1'b0, it.link_metric} + {1'b0, it.advertised_distance};
      cost = sum[16] ? dvru_pkg::COST_MAX : sum[15:0];
      hit = -1;
      for (int i = 0; i < rt_count; i++) begin
        if (hit < 0 && rt_dest[i] == it.dest_addr) hit = i;
      end
      if (hit >= 0) begin
        if (cost < rt_cost[hit]) begin
          rt_hop[hit] = it.neighbor_addr;
          rt_cost[hit] = cost;
          r.changed = 1'b1;
        end
      end else if (rt_count < dvru_pkg::ROUTE_ENTRIES) begin
        rt_dest[rt_count] = it.dest_addr;
        rt_hop[rt_count] = it.neighbor_addr;
        rt_cost[rt_count] = cost;
        rt_count++;
        r.changed = 1'b1;
      end else begin
        r.table_full_drop = 1'b1;
      end
      if (r.changed) pass_acc = 1'b1;
      if (it.last_of_pass) begin
        r.pass_changed = pass_acc;
        pass_acc = 1'b0;
      end
    end
    r.entry_count = 7'(rt_count);
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fault_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic dvru_pkg::in_t make_update(logic [31:0] nbr, logic [15:0] link,
                                                logic [31:0] dst, logic [15:0] adv_dist,
                                                logic last);
    dvru_pkg::in_t it;
    it.req_type = dvru_pkg::REQ_UPDATE;
    it.neighbor_addr = nbr;
    it.link_metric = link;
    it.dest_addr = dst;
    it.advertised_distance = adv_dist;
    it.read_index = 6'($urandom);
    it.last_of_pass = last;
    return it;
  endfunction

  function automatic dvru_pkg::in_t make_read(logic [5:0] idx);
    dvru_pkg::in_t it;
    it.req_type = dvru_pkg::REQ_READ;
    it.neighbor_addr = $urandom;
    it.link_metric = 16'($urandom);
    it.dest_addr = $urandom;
    it.advertised_distance = 16'($urandom);
    it.read_index = idx;
    it.last_of_pass = 1'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] rand_cost();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 300));
  endfunction

  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  task automatic add_update(logic [31:0] nbr, logic [15:0] link, logic [31:0] dst,
                            logic [15:0] adv_dist, logic last);
    adverts.push_back(make_update(nbr, link, dst, adv_dist, last));
    dest_pool.push_back(dst);
  endtask

  // mixed traffic: reads, updates to known destinations and new ones
  task automatic add_mixed(int n);
    logic [31:0] dst;
    int hi;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        hi = (dest_pool.size() > dvru_pkg::ROUTE_ENTRIES) ? dvru_pkg::ROUTE_ENTRIES
                                                          : dest_pool.size();
        if (hi == 0 || $urandom_range(0, 9) < 3)
          adverts.push_back(make_read(6'($urandom)));
        else
          adverts.push_back(make_read(6'($urandom_range(0, hi - 1))));
      end else begin
        if (dest_pool.size() > 0 && $urandom_range(0, 9) < 7)
          dst = dest_pool[$urandom_range(0, dest_pool.size() - 1)];
        else
          dst = $urandom;
        add_update($urandom, rand_cost(), dst, rand_cost(), $urandom_range(0, 5) == 0);
      end
    end
  endtask

  // driver
  always @(negedge clk) begin : drv
    logic nxt_start;
    dvru_pkg::in_t nxt_item;
    nxt_start = start;
    nxt_item = in_item;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else begin
      if (start && item_taken) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (adverts.size() > 0) begin
          nxt_item = adverts.pop_front();
          nxt_start = 1'b1;
          gap_left = next_gap();
        end
      end
    end
    start <= nxt_start;
    in_item <= nxt_item;
  end

  // monitor
  always @(posedge clk) begin : mon
    dvru_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (route_replies.size() == 0) begin
          report_error($sformatf("result with none expected: %h", out_res));
        end else begin
          want = route_replies.pop_front();
          check_field("changed", 32'(out_res.changed), 32'(want.changed));
          check_field("pass_changed", 32'(out_res.pass_changed), 32'(want.pass_changed));
          check_field("table_full_drop", 32'(out_res.table_full_drop),
                      32'(want.table_full_drop));
          check_field("entry_valid", 32'(out_res.entry_valid), 32'(want.entry_valid));
          check_field("entry_dest", out_res.entry_dest, want.entry_dest);
          check_field("entry_next_hop", out_res.entry_next_hop, want.entry_next_hop);
          check_field("entry_cost", 32'(out_res.entry_cost), 32'(want.entry_cost));
          check_field("entry_count", 32'(out_res.entry_count), 32'(want.entry_count));
        end
      end
      if (start && !busy) route_replies.push_back(relax_route(in_item));
      item_taken <= start && !busy;
    end else begin
      item_taken <= 1'b0;
    end
  end

  initial begin
    rst_n = 1'b0;

    // empty table reads, extremes, saturation, equal cost, pass flag
    adverts.push_back(make_read(6'd0));
    adverts.push_back(make_read(6'd63));
    add_update(32'h0, 16'h0, 32'h0, 16'h0, 1'b1);
    add_update(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    add_update(32'h0A00_0002, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 1'b0);
    add_update(32'h0A00_0003, 16'h1, 32'hFFFF_FFFF, 16'hFFFE, 1'b1);
    add_update(32'h0A00_0001, 16'd100, 32'hFFFF_FFFF, 16'd200, 1'b0);
    add_update(32'h0A00_0004, 16'h0, 32'h0, 16'h0, 1'b1);
    add_update(32'h0A00_0005, 16'h0, 32'h0, 16'h0, 1'b1);
    add_update(32'h0A00_0006, 16'd300, 32'hFFFF_FFFF, 16'h0, 1'b0);
    add_update(32'h0A00_0007, 16'd299, 32'hFFFF_FFFF, 16'h0, 1'b0);
    add_update(32'h0A00_0008, 16'd5, 32'hC0A8_0001, 16'd7, 1'b0);
    add_update(32'h0A00_0009, 16'h8000, 32'hC0A8_0001, 16'h8000, 1'b1);
    adverts.push_back(make_read(6'd0));
    adverts.push_back(make_read(6'd1));
    adverts.push_back(make_read(6'd2));
    adverts.push_back(make_read(6'd3));
    adverts.push_back(make_read(6'd63));
    add_update(32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 16'hAAAA, 1'b1);
    adverts.push_back(make_read(6'd3));

    add_mixed(150);
    // fresh destinations until the table overflows
    for (int k = 0; k < 70; k++)
      add_update($urandom, rand_cost(), $urandom, rand_cost(), $urandom_range(0, 7) == 0);
    add_mixed(200);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (adverts.size() != 0 || start) @(posedge clk);
    while (route_replies.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (fault_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #1500000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/dvru_pkg.sv
rtl/dvru_ram.sv
rtl/distance_vector_route_update.sv
rtl/dvru_checker.sv
sim/distance_vector_route_update_tb.sv
